[hw/rtl/barometric_sensor_compensation_top_macros.svh]
// assertion macros for the barometric compensation block
// used by the port checker; expects clk and rst_n in scope
`ifndef BAROMETRIC_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("barometric compensation port check failed");

// next-cycle implication, disabled in reset
`define BSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("barometric compensation port check failed");

`endif

[hw/rtl/bsc_pkg.sv]
// shared types, widths and constants for the barometric compensation block
// no dependencies; used by every rtl file of the block
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int ADC_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_P9   = 2'd3;

    localparam int TEMP_W     = 16;
    localparam int V_W        = 25;
    localparam int DIVIDEND_W = 76;
    localparam int DEN_W      = 41;
    localparam int QUO_W      = 36;
    localparam int DIV_STEPS  = QUO_W;

    localparam int TEMP_STAGES  = 4;
    localparam int FRONT_STAGES = 7;
    localparam int POST_STAGES  = 5;
    localparam int LATENCY = 1 + TEMP_STAGES + FRONT_STAGES + 1 + DIV_STEPS + POST_STAGES;

    localparam logic signed [V_W-1:0] T_FINE_OFFSET = 25'sd128000;
    localparam logic [11:0]           PAS_SCALE     = 12'd3125;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coeff_t;

    typedef struct packed {
        logic                     valid;
        logic signed [V_W-1:0]    v;
        logic signed [TEMP_W-1:0] temp;
        logic        [ADC_W-1:0]  adc_p;
    } temp_out_t;

    typedef struct packed {
        logic                     valid;
        logic [DIVIDEND_W-1:0]    dividend;
        logic [DEN_W-1:0]         divisor;
        logic signed [TEMP_W-1:0] temp;
        logic                     neg;
        logic                     dz;
    } front_out_t;

    typedef struct packed {
        logic                     valid;
        logic [QUO_W-1:0]         quo;
        logic signed [TEMP_W-1:0] temp;
        logic                     neg;
        logic                     dz;
        logic                     ovf;
    } div_out_t;

endpackage

[hw/rtl/bsc_temp.sv]
// temperature stages: fine temperature, centidegrees and pressure offset v
// depends on bsc_pkg
`timescale 1ns / 1ps

module bsc_temp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [bsc_pkg::ADC_W-1:0]   adc_t,
    input  logic [bsc_pkg::ADC_W-1:0]   adc_p,
    input  bsc_pkg::coeff_t             coeff,
    output bsc_pkg::temp_out_t          tout
);

    logic [bsc_pkg::TEMP_STAGES-1:0] vld_reg;
    logic [bsc_pkg::ADC_W-1:0]       adc_p_reg [0:bsc_pkg::TEMP_STAGES-1];

    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [33:0] m1_next;
    logic signed [33:0] dd_next;
    logic signed [33:0] m1_reg;
    logic        [31:0] dd_reg;

    logic signed [22:0] a1_next;
    logic signed [36:0] m2_next;
    logic signed [22:0] a1_reg;
    logic signed [36:0] m2_reg;

    logic signed [23:0] tf_next;
    logic signed [23:0] tf_reg;

    logic signed [26:0] t5;
    logic signed [18:0] tq;
    logic signed [bsc_pkg::TEMP_W-1:0] temp_next;
    logic signed [bsc_pkg::V_W-1:0]    v_next;
    logic signed [bsc_pkg::TEMP_W-1:0] temp_reg;
    logic signed [bsc_pkg::V_W-1:0]    v_reg;

    always_comb
    begin
        d1      = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
        d2      = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, coeff.t1});
        m1_next = d1 * $signed(coeff.t2);
        dd_next = d2 * d2;
        // floor shifts are upper slices of the products
        a1_next = $signed(m1_reg[33:11]);
        m2_next = $signed({1'b0, dd_reg[31:12]}) * $signed(coeff.t3);
        tf_next = $signed(a1_reg) + $signed(m2_reg[36:14]);
        t5      = tf_reg * 27'sd5 + 27'sd128;
        tq      = $signed(t5[26:8]);
        if (tq > 19'sd32767)
        begin
            temp_next = 16'sh7fff;
        end
        else if (tq < -19'sd32768)
        begin
            temp_next = 16'sh8000;
        end
        else
        begin
            temp_next = tq[15:0];
        end
        v_next = 25'(tf_reg) - bsc_pkg::T_FINE_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[bsc_pkg::TEMP_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        adc_p_reg[0] <= adc_p;
        for (int k = 1; k < bsc_pkg::TEMP_STAGES; k++)
        begin
            adc_p_reg[k] <= adc_p_reg[k-1];
        end
        m1_reg   <= m1_next;
        dd_reg   <= dd_next[31:0];
        a1_reg   <= a1_next;
        m2_reg   <= m2_next;
        tf_reg   <= tf_next;
        temp_reg <= temp_next;
        v_reg    <= v_next;
    end

    always_comb
    begin
        tout.valid = vld_reg[bsc_pkg::TEMP_STAGES-1];
        tout.v     = v_reg;
        tout.temp  = temp_reg;
        tout.adc_p = adc_p_reg[bsc_pkg::TEMP_STAGES-1];
    end

endmodule

[hw/rtl/bsc_front.sv]
// pressure stages ahead of the divider: numerator, divisor, magnitudes
// depends on bsc_pkg; fed by bsc_temp
`timescale 1ns / 1ps

module bsc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsc_pkg::temp_out_t   tin,
    input  bsc_pkg::coeff_t      coeff,
    output bsc_pkg::front_out_t  fout
);

    localparam logic signed [55:0] A_BIAS = 56'sd1 <<< 47;

    logic [bsc_pkg::FRONT_STAGES-1:0] vld_reg;
    logic [bsc_pkg::TEMP_W-1:0]       temp_reg [0:bsc_pkg::FRONT_STAGES-1];

    // stage 1
    logic signed [49:0] vv_full;
    logic signed [45:0] vv_reg;
    logic signed [40:0] vp5_next, vp2_next;
    logic signed [40:0] vp5_reg, vp2_reg;
    logic [20:0] base_next;
    logic [20:0] base1_reg, base2_reg, base3_reg;
    // stage 2
    logic signed [61:0] vvp6_next, vvp3_next;
    logic signed [61:0] vvp6_reg, vvp3_reg;
    logic signed [40:0] vp5_2_reg, vp2_2_reg;
    // stage 3
    logic signed [63:0] num_off_next;
    logic signed [55:0] a_next;
    logic signed [63:0] num_off_reg;
    logic signed [55:0] a_reg;
    // stage 4
    logic signed [63:0] num_next;
    logic signed [39:0] ahp1_next;
    logic        [48:0] alp1_next;
    logic signed [63:0] num4_reg;
    logic signed [39:0] ahp1_reg;
    logic        [48:0] alp1_reg;
    // stage 5
    logic signed [40:0] den_next;
    logic signed [40:0] den_reg;
    logic signed [63:0] num5_reg;
    // stage 6
    logic [63:0] mn_next;
    logic [bsc_pkg::DEN_W-1:0] md_next;
    logic [63:0] mn_reg;
    logic [bsc_pkg::DEN_W-1:0] md6_reg, md7_reg;
    logic neg6_reg, dz6_reg, neg7_reg, dz7_reg;
    // stage 7
    logic [bsc_pkg::DIVIDEND_W-1:0] dividend_next;
    logic [bsc_pkg::DIVIDEND_W-1:0] dividend_reg;

    always_comb
    begin
        vv_full   = $signed(tin.v) * $signed(tin.v);
        vp5_next  = $signed(tin.v) * $signed(coeff.p5);
        vp2_next  = $signed(tin.v) * $signed(coeff.p2);
        base_next = 21'd1048576 - {1'b0, tin.adc_p};

        vvp6_next = vv_reg * $signed(coeff.p6);
        vvp3_next = vv_reg * $signed(coeff.p3);

        num_off_next = 64'(vvp6_reg) + (64'(vp5_2_reg) <<< 17)
                     + (64'($signed(coeff.p4)) <<< 35);
        a_next = 56'($signed(vvp3_reg[61:8])) + (56'(vp2_2_reg) <<< 12) + A_BIAS;

        num_next  = $signed({12'd0, base3_reg, 31'd0}) - num_off_reg;
        // divisor = (a * p1) >>> 33, split at bit 33 of a
        ahp1_next = $signed(a_reg[55:33]) * $signed({1'b0, coeff.p1});
        alp1_next = 49'(a_reg[32:0]) * 49'(coeff.p1);

        den_next = 41'(ahp1_reg) + $signed({25'd0, alp1_reg[48:33]});

        mn_next = num5_reg[63] ? 64'(-num5_reg) : 64'(num5_reg);
        md_next = den_reg[40] ? 41'(-den_reg) : 41'(den_reg);

        // quotient is taken in 1/3125 of a Q.8 step, so scale the numerator
        dividend_next = 76'(mn_reg) * 76'(bsc_pkg::PAS_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[bsc_pkg::FRONT_STAGES-2:0], tin.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg[0] <= tin.temp;
        for (int k = 1; k < bsc_pkg::FRONT_STAGES; k++)
        begin
            temp_reg[k] <= temp_reg[k-1];
        end
        vv_reg       <= vv_full[45:0];
        vp5_reg      <= vp5_next;
        vp2_reg      <= vp2_next;
        base1_reg    <= base_next;
        vvp6_reg     <= vvp6_next;
        vvp3_reg     <= vvp3_next;
        vp5_2_reg    <= vp5_reg;
        vp2_2_reg    <= vp2_reg;
        base2_reg    <= base1_reg;
        num_off_reg  <= num_off_next;
        a_reg        <= a_next;
        base3_reg    <= base2_reg;
        num4_reg     <= num_next;
        ahp1_reg     <= ahp1_next;
        alp1_reg     <= alp1_next;
        den_reg      <= den_next;
        num5_reg     <= num4_reg;
        mn_reg       <= mn_next;
        md6_reg      <= md_next;
        neg6_reg     <= num5_reg[63] ^ den_reg[40];
        dz6_reg      <= (den_reg == 41'sd0);
        dividend_reg <= dividend_next;
        md7_reg      <= md6_reg;
        neg7_reg     <= neg6_reg;
        dz7_reg      <= dz6_reg;
    end

    always_comb
    begin
        fout.valid    = vld_reg[bsc_pkg::FRONT_STAGES-1];
        fout.dividend = dividend_reg;
        fout.divisor  = md7_reg;
        fout.temp     = temp_reg[bsc_pkg::FRONT_STAGES-1];
        fout.neg      = neg7_reg;
        fout.dz       = dz7_reg;
    end

endmodule

[hw/rtl/bsc_div.sv]
// pipelined restoring divider, one quotient bit per stage, with an overflow flag
// depends on bsc_pkg; fed by bsc_front
`timescale 1ns / 1ps

module bsc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsc_pkg::front_out_t  fin,
    output bsc_pkg::div_out_t    dout
);

    localparam int N  = bsc_pkg::DIV_STEPS;
    localparam int DW = bsc_pkg::DEN_W;
    localparam int QW = bsc_pkg::QUO_W;
    localparam int HW = bsc_pkg::DIVIDEND_W - QW;

    logic                        vld_reg  [0:N];
    logic [DW-1:0]               rem_reg  [0:N-1];
    logic [QW-1:0]               lq_reg   [0:N];
    logic [DW-1:0]               md_reg   [0:N];
    logic [bsc_pkg::TEMP_W-1:0]  temp_reg [0:N];
    logic                        neg_reg  [0:N];
    logic                        dz_reg   [0:N];
    logic                        ovf_reg  [0:N];

    logic [DW:0] trial [0:N-1];
    logic [DW:0] diff  [0:N-1];
    logic        take  [0:N-1];
    logic        ovf_next;

    // quotient fits only if the upper part of the dividend is below the divisor
    assign ovf_next = DW'(fin.dividend[bsc_pkg::DIVIDEND_W-1:QW]) >= fin.divisor;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            trial[k] = {rem_reg[k], lq_reg[k][QW-1]};
            diff[k]  = trial[k] - {1'b0, md_reg[k]};
            take[k]  = trial[k] >= {1'b0, md_reg[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= fin.valid;
            for (int k = 1; k <= N; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DW'(fin.dividend[HW+QW-1:QW]);
        lq_reg[0]   <= fin.dividend[QW-1:0];
        md_reg[0]   <= fin.divisor;
        temp_reg[0] <= fin.temp;
        neg_reg[0]  <= fin.neg;
        dz_reg[0]   <= fin.dz;
        ovf_reg[0]  <= ovf_next;
        // the last stage only needs its quotient bit
        for (int k = 0; k < N-1; k++)
        begin
            rem_reg[k+1] <= take[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
        end
        for (int k = 0; k < N; k++)
        begin
            lq_reg[k+1]   <= {lq_reg[k][QW-2:0], take[k]};
            md_reg[k+1]   <= md_reg[k];
            temp_reg[k+1] <= temp_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            dz_reg[k+1]   <= dz_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
        end
    end

    always_comb
    begin
        dout.valid = vld_reg[N];
        dout.quo   = lq_reg[N];
        dout.temp  = temp_reg[N];
        dout.neg   = neg_reg[N];
        dout.dz    = dz_reg[N];
        dout.ovf   = ovf_reg[N];
    end

endmodule

[hw/rtl/bsc_post.sv]
// signed quotient, second-order correction and output saturation
// depends on bsc_pkg; fed by bsc_div
`timescale 1ns / 1ps

module bsc_post (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bsc_pkg::div_out_t              din,
    input  bsc_pkg::coeff_t                coeff,
    output logic                           done,
    output logic [bsc_pkg::TEMP_W-1:0]     temperature_centidegrees,
    output logic [31:0]                    pressure_pascal_q8,
    output logic                           divide_by_zero
);

    localparam int S  = bsc_pkg::POST_STAGES;
    localparam int QW = bsc_pkg::QUO_W;

    logic [S-1:0]               vld_reg;
    logic [bsc_pkg::TEMP_W-1:0] temp_reg [0:S-1];
    logic [S-1:0]               dz_reg;

    logic [QW-1:0]      lim;
    logic [QW-1:0]      mag;
    logic signed [36:0] p_next;
    logic signed [36:0] p1_reg, p2_reg, p3_reg;

    logic signed [47:0] psps_full;
    logic signed [52:0] p8p_next;
    logic signed [46:0] psps_reg;
    logic signed [52:0] p8p_reg;

    logic signed [62:0] c1m_next;
    logic signed [62:0] c1m_reg;
    logic signed [33:0] c2_reg;

    logic signed [39:0] s_next;
    logic signed [39:0] s_reg;

    logic signed [33:0] r;
    logic [31:0]        pres_next;
    logic [31:0]        pres_reg;

    always_comb
    begin
        lim = din.neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        mag = (din.ovf || din.quo > lim) ? lim : din.quo;
        p_next = din.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        psps_full = $signed(p1_reg[36:13]) * $signed(p1_reg[36:13]);
        p8p_next  = $signed(coeff.p8) * p1_reg;

        c1m_next = $signed(coeff.p9) * psps_reg;

        s_next = 40'(p3_reg) + 40'($signed(c1m_reg[62:25])) + 40'(c2_reg);

        r = 34'($signed(s_reg[39:8])) + (34'($signed(coeff.p7)) <<< 4);
        if (dz_reg[S-2] || r < 34'sd0)
        begin
            pres_next = 32'd0;
        end
        else if (r[33:32] != 2'b00)
        begin
            pres_next = 32'hffff_ffff;
        end
        else
        begin
            pres_next = r[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[S-2:0], din.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg[0] <= din.temp;
        for (int k = 1; k < S; k++)
        begin
            temp_reg[k] <= temp_reg[k-1];
        end
        dz_reg   <= {dz_reg[S-2:0], din.dz};
        p1_reg   <= p_next;
        psps_reg <= psps_full[46:0];
        p8p_reg  <= p8p_next;
        p2_reg   <= p1_reg;
        c1m_reg  <= c1m_next;
        c2_reg   <= $signed(p8p_reg[52:19]);
        p3_reg   <= p2_reg;
        s_reg    <= s_next;
        pres_reg <= pres_next;
    end

    assign done                     = vld_reg[S-1];
    assign temperature_centidegrees = temp_reg[S-1];
    assign pressure_pascal_q8       = pres_reg;
    assign divide_by_zero           = dz_reg[S-1];

endmodule

[hw/rtl/barometric_sensor_compensation_top.sv]
// top level of the barometric compensation block: config registers, input stage
// depends on bsc_pkg, bsc_temp, bsc_front, bsc_div and bsc_post
//
// usage:
//   - load calibration through cfg_write / cfg_index / cfg_data while no item is
//     in flight; index 0 temperature words, 1 and 2 pressure words, 3 is P9
//   - an item (raw_temperature, raw_pressure) is taken at an edge with start high
//     and busy low; busy is high only in the first cycle after reset
//   - one item per cycle is taken while busy is low; every item gives one result
//   - the result is on the output ports for one cycle with done high, after the
//     input stage, 4 temperature stages, 7 pressure stages, divider setup plus
//     36 quotient-bit stages and 5 correction stages; the 36-stage divider is
//     the longest part of that path
//   - the receiver cannot hold results off, so there is no stall path
//   - reset clears all calibration words and drops every item in flight
`timescale 1ns / 1ps

module barometric_sensor_compensation_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bsc_pkg::ADC_W-1:0]           raw_temperature,
    input  logic [bsc_pkg::ADC_W-1:0]           raw_pressure,
    input  logic                                cfg_write,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                done,
    output logic signed [bsc_pkg::TEMP_W-1:0]   temperature_centidegrees,
    output logic [31:0]                         pressure_pascal_q8,
    output logic                                divide_by_zero
);

    logic [47:0] temp_cal_reg;
    logic [63:0] pres_low_reg;
    logic [63:0] pres_high_reg;
    logic [15:0] p9_reg;
    logic        busy_reg;

    logic                      in_valid_reg;
    logic [bsc_pkg::ADC_W-1:0] adc_t_reg;
    logic [bsc_pkg::ADC_W-1:0] adc_p_reg;
    logic                      accept;

    bsc_pkg::coeff_t     coeff;
    bsc_pkg::temp_out_t  temp_out;
    bsc_pkg::front_out_t front_out;
    bsc_pkg::div_out_t   div_out;
    logic [bsc_pkg::TEMP_W-1:0] temp_bits;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg  <= '0;
            pres_low_reg  <= '0;
            pres_high_reg <= '0;
            p9_reg        <= '0;
            busy_reg      <= 1'b1;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg     <= 1'b0;
            in_valid_reg <= accept;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bsc_pkg::CFG_TEMP_CAL:  temp_cal_reg  <= cfg_data[47:0];
                    bsc_pkg::CFG_PRES_LOW:  pres_low_reg  <= cfg_data;
                    bsc_pkg::CFG_PRES_HIGH: pres_high_reg <= cfg_data;
                    bsc_pkg::CFG_PRES_P9:   p9_reg        <= cfg_data[15:0];
                    default:                p9_reg        <= p9_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        adc_t_reg <= raw_temperature;
        adc_p_reg <= raw_pressure;
    end

    always_comb
    begin
        coeff.t1 = temp_cal_reg[15:0];
        coeff.t2 = temp_cal_reg[31:16];
        coeff.t3 = temp_cal_reg[47:32];
        coeff.p1 = pres_low_reg[15:0];
        coeff.p2 = pres_low_reg[31:16];
        coeff.p3 = pres_low_reg[47:32];
        coeff.p4 = pres_low_reg[63:48];
        coeff.p5 = pres_high_reg[15:0];
        coeff.p6 = pres_high_reg[31:16];
        coeff.p7 = pres_high_reg[47:32];
        coeff.p8 = pres_high_reg[63:48];
        coeff.p9 = p9_reg;
    end

    bsc_temp u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .adc_t    (adc_t_reg),
        .adc_p    (adc_p_reg),
        .coeff    (coeff),
        .tout     (temp_out)
    );

    bsc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .tin   (temp_out),
        .coeff (coeff),
        .fout  (front_out)
    );

    bsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .fin   (front_out),
        .dout  (div_out)
    );

    bsc_post u_post (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .din                      (div_out),
        .coeff                    (coeff),
        .done                     (done),
        .temperature_centidegrees (temp_bits),
        .pressure_pascal_q8       (pressure_pascal_q8),
        .divide_by_zero           (divide_by_zero)
    );

    assign temperature_centidegrees = $signed(temp_bits);

endmodule

[hw/rtl/bsc_checker.sv]
// port-level checks for the barometric compensation top, attached by bind
// depends on bsc_pkg and barometric_sensor_compensation_top_macros.svh
`timescale 1ns / 1ps
`include "barometric_sensor_compensation_top_macros.svh"

module bsc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [31:0]                         pressure_pascal_q8,
    input  logic                                divide_by_zero
);

    // a zero divisor always reports zero pressure
    `BSC_ASSERT_SAME(a_dz_zero, done && divide_by_zero, pressure_pascal_q8 == 32'd0)

    // once ready, the block stays ready
    `BSC_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)

    // every result comes from an item taken with start high and busy low, delayed through the whole pipeline
    `BSC_ASSERT_SAME(a_done_latency, done, $past(start && !busy, bsc_pkg::LATENCY))

endmodule

bind barometric_sensor_compensation_top bsc_checker u_bsc_checker (.*);

[tb/testbench.sv]
// self-checking testbench for barometric_sensor_compensation_top
// depends on bsc_pkg and the block's rtl; predicts each result and checks it in order
`timescale 1ns / 1ps

module testbench;
    import bsc_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [ADC_W-1:0] raw_t;
        logic [ADC_W-1:0] raw_p;
    } reading_t;

    typedef struct {
        logic signed [15:0] temp;
        logic [31:0]        pres;
        logic               dz;
    } compensated_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [ADC_W-1:0]      raw_temperature;
    logic [ADC_W-1:0]      raw_pressure;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic signed [15:0]    temperature_centidegrees;
    logic [31:0]           pressure_pascal_q8;
    logic                  divide_by_zero;

    // calibration words as the block holds them
    logic [47:0] temp_cal;
    logic [63:0] pres_low;
    logic [63:0] pres_high;
    logic [15:0] p9_word;

    reading_t     pending_readings[$];
    compensated_t expected_results[$];
    int           error_count;
    int           burst_left;
    int           gap_left;

    barometric_sensor_compensation_top i_dut (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .start                    (start),
        .busy                     (busy),
        .raw_temperature          (raw_temperature),
        .raw_pressure             (raw_pressure),
        .cfg_write                (cfg_write),
        .cfg_index                (cfg_index),
        .cfg_data                 (cfg_data),
        .done                     (done),
        .temperature_centidegrees (temperature_centidegrees),
        .pressure_pascal_q8       (pressure_pascal_q8),
        .divide_by_zero           (divide_by_zero)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // exact-width compensation of one reading pair
    function automatic compensated_t compensate(logic [ADC_W-1:0] raw_t,
                                                logic [ADC_W-1:0] raw_p);
        compensated_t res;
        wide_t one, at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        wide_t d1, d2, t_fine, temp, v, num_off, a, ah, al, den, num;
        wide_t mn, md, qa, ra, lim, mag, p, ps, c1, c2, r;
        logic neg;
        one = 1;
        at = raw_t;
        ap = raw_p;
        t1 = temp_cal[15:0];
        t2 = $signed(temp_cal[31:16]);
        t3 = $signed(temp_cal[47:32]);
        p1 = pres_low[15:0];
        p2 = $signed(pres_low[31:16]);
        p3 = $signed(pres_low[47:32]);
        p4 = $signed(pres_low[63:48]);
        p5 = $signed(pres_high[15:0]);
        p6 = $signed(pres_high[31:16]);
        p7 = $signed(pres_high[47:32]);
        p8 = $signed(pres_high[63:48]);
        p9 = $signed(p9_word);

        d1 = (at >>> 3) - t1 * 2;
        d2 = (at >>> 4) - t1;
        t_fine = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
        temp = (t_fine * 5 + 128) >>> 8;
        if (temp > 32767)
            temp = 32767;
        if (temp < -32768)
            temp = -32768;
        res.temp = temp[15:0];

        v = t_fine - 128000;
        num_off = v * v * p6 + v * p5 * (one <<< 17) + p4 * (one <<< 35);
        a = ((v * v * p3) >>> 8) + v * p2 * (one <<< 12) + (one <<< 47);
        ah = a >>> 33;
        al = a - (ah <<< 33);
        den = ah * p1 + ((al * p1) >>> 33);

        res.pres = '0;
        res.dz = 1'b0;
        if (den == 0)
        begin
            res.dz = 1'b1;
        end
        else
        begin
            num = ((one <<< 20) - ap) * (one <<< 31) - num_off;
            neg = (num < 0) != (den < 0);
            mn = (num < 0) ? -num : num;
            md = (den < 0) ? -den : den;
            qa = mn / md;
            ra = mn % md;
            lim = neg ? (one <<< 35) : (one <<< 35) - 1;
            if (qa >= (one <<< 35))
            begin
                mag = lim;
            end
            else
            begin
                mag = qa * 3125 + (ra * 3125) / md;
                if (mag > lim)
                    mag = lim;
            end
            p = neg ? -mag : mag;
            ps = p >>> 13;
            c1 = (p9 * ps * ps) >>> 25;
            c2 = (p8 * p) >>> 19;
            r = ((p + c1 + c2) >>> 8) + p7 * 16;
            if (r < 0)
                r = 0;
            if (r > 64'hFFFF_FFFF)
                r = 64'hFFFF_FFFF;
            res.pres = r[31:0];
        end
        return res;
    endfunction

    // driver: bursts of items with random gaps
    always @(posedge clk)
    begin
        reading_t rd;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                rd = pending_readings.pop_front();
                expected_results.push_back(compensate(rd.raw_t, rd.raw_p));
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_readings.size() > 0)
                begin
                    rd = pending_readings[0];
                    start <= 1'b1;
                    raw_temperature <= rd.raw_t;
                    raw_pressure <= rd.raw_p;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        compensated_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: temp %0d pressure %0d",
                       temperature_centidegrees, pressure_pascal_q8);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (temperature_centidegrees !== exp_res.temp)
                begin
                    $error("temperature_centidegrees: expected %0d, got %0d",
                           exp_res.temp, temperature_centidegrees);
                    error_count++;
                end
                if (pressure_pascal_q8 !== exp_res.pres)
                begin
                    $error("pressure_pascal_q8: expected %0d, got %0d",
                           exp_res.pres, pressure_pascal_q8);
                    error_count++;
                end
                if (divide_by_zero !== exp_res.dz)
                begin
                    $error("divide_by_zero: expected %0d, got %0d",
                           exp_res.dz, divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_TEMP_CAL:  temp_cal = value[47:0];
            CFG_PRES_LOW:  pres_low = value;
            CFG_PRES_HIGH: pres_high = value;
            CFG_PRES_P9:   p9_word = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(logic [47:0] tc, logic [63:0] pl, logic [63:0] ph,
                                    logic [15:0] nine);
        write_reg(CFG_TEMP_CAL, {16'hFFFF, tc});
        write_reg(CFG_PRES_LOW, pl);
        write_reg(CFG_PRES_HIGH, ph);
        write_reg(CFG_PRES_P9, {48'hFFFF_FFFF_FFFF, nine});
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_readings.size() > 0 || expected_results.size() > 0 || start)
            @(posedge clk);
    endtask

    task automatic queue_reading(logic [ADC_W-1:0] rt, logic [ADC_W-1:0] rp);
        reading_t rd;
        rd.raw_t = rt;
        rd.raw_p = rp;
        pending_readings.push_back(rd);
    endtask

    function automatic logic [15:0] jitter(logic [15:0] base);
        return base + 16'($urandom_range(0, 400)) - 16'd200;
    endfunction

    initial
    begin
        logic [15:0] w[12];
        int mode;
        rst_n = 1'b0;
        start = 1'b0;
        raw_temperature = '0;
        raw_pressure = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        temp_cal = '0;
        pres_low = '0;
        pres_high = '0;
        p9_word = '0;
        error_count = 0;
        burst_left = 1;
        gap_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: divisor is zero for every item
        queue_reading(20'h0, 20'h0);
        queue_reading(20'hFFFFF, 20'hFFFFF);
        queue_reading(20'h80000, 20'h66666);
        wait_idle();

        // typical datasheet calibration, field extremes
        load_calibration({16'hFC18, 16'd26435, 16'd27504},
                         {16'd2855, 16'd3024, 16'hD943, 16'd36477},
                         {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        queue_reading(20'h0, 20'h0);
        queue_reading(20'hFFFFF, 20'h0);
        queue_reading(20'h0, 20'hFFFFF);
        queue_reading(20'hFFFFF, 20'hFFFFF);
        queue_reading(20'd519888, 20'd415148);
        queue_reading(20'h7FFFF, 20'h80000);
        wait_idle();

        // all ones / all positive max / signed fields at negative min calibration, t1 and p1 all ones
        load_calibration('1, '1, '1, '1);
        queue_reading(20'h0, 20'h0);
        queue_reading(20'hFFFFF, 20'hFFFFF);
        queue_reading(20'h55555, 20'hAAAAA);
        wait_idle();
        load_calibration({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
        queue_reading(20'h0, 20'h0);
        queue_reading(20'hFFFFF, 20'hFFFFF);
        queue_reading(20'h12345, 20'hFEDCB);
        wait_idle();
        load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
                         {4{16'h8000}}, 16'h8000);
        queue_reading(20'h0, 20'h0);
        queue_reading(20'hFFFFF, 20'hFFFFF);
        queue_reading(20'h40000, 20'h20000);
        wait_idle();

        // random phases: mostly near-typical calibration, some wild or zero p1
        for (int ph = 0; ph < 16; ph++)
        begin
            mode = $urandom_range(0, 9);
            w = '{16'd27504, 16'd26435, 16'hFC18, 16'd36477, 16'hD943, 16'd3024,
                  16'd2855, 16'd140, 16'hFFF9, 16'd15500, 16'hC6F8, 16'd6000};
            for (int k = 0; k < 12; k++)
            begin
                if (mode < 6)
                    w[k] = jitter(w[k]);
                else
                    w[k] = 16'($urandom());
            end
            if (mode == 9)
                w[3] = '0;
            load_calibration({w[2], w[1], w[0]}, {w[6], w[5], w[4], w[3]},
                             {w[10], w[9], w[8], w[7]}, w[11]);
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_reading(20'($urandom()), 20'($urandom()));
                else
                    queue_reading(20'($urandom_range(400000, 640000)),
                                  20'($urandom_range(200000, 700000)));
            end
            wait_idle();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
